/* hw/rtl/rtc_pkg.sv */
`default_nettype none
package rtc_pkg;

  // Vector sizes, fixed by the port fields.
  localparam int XN = 8;
  localparam int HN = 4;
  localparam int W_DEPTH = XN * HN;
  localparam int U_DEPTH = HN * HN;
  localparam int W_AW = $clog2(W_DEPTH);
  localparam int U_AW = $clog2(U_DEPTH);
  localparam int TERMS = XN + HN;
  localparam int TERM_W = $clog2(TERMS);
  localparam int ROW_W = $clog2(HN);
  localparam int XK_W = $clog2(XN);

  // Accumulator: sums of 27-fraction-bit products stay well below 2^37.
  localparam int ACC_W = 39;

  // tanh table: 256 segments over [0, 8), Q1.14 entries.
  localparam int TAB_N = 256;
  localparam int TAB_AW = $clog2(TAB_N + 1);
  localparam int SEG_W = $clog2(TAB_N);
  localparam int FRAC_W = 30 - SEG_W;
  localparam int H_ONE = 16384;

  typedef logic signed [15:0] word_t;
  typedef word_t xvec_t [XN];
  typedef word_t hvec_t [HN];
  typedef word_t w_init_t [W_DEPTH];
  typedef word_t u_init_t [U_DEPTH];
  typedef logic [14:0] tanh_tab_t [TAB_N + 1];

  typedef enum logic [1:0] {
    KIND_LOAD_W = 2'd0,
    KIND_LOAD_U = 2'd1,
    KIND_STEP   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic              load_w;
    logic              load_u;
    logic              start;
    logic              acc_clr;
    logic              issue;
    logic [TERM_W-1:0] term;
    logic [ROW_W-1:0]  row;
    logic              abs_cap;
    logic              tab_lo;
    logic              tab_hi;
    logic              tab_mul;
    logic              h_wr;
    logic              commit;
  } rtc_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } rtc_sts_t;

  // Trained input kernel, stored row by row (hidden row, then input column).
  localparam w_init_t W_INIT = '{
    16'sd5300,  16'sd531,   -16'sd477,  -16'sd495,  16'sd2583,  16'sd3968,  -16'sd3370, -16'sd1797,
    16'sd1545,  -16'sd5367, 16'sd1273,  16'sd1247,  16'sd948,   16'sd1828,  -16'sd5390, -16'sd4514,
    -16'sd4292, 16'sd2147,  16'sd1212,  -16'sd3944, -16'sd1137, -16'sd2654, 16'sd5655,  16'sd492,
    -16'sd4216, -16'sd3925, -16'sd4476, -16'sd915,  16'sd5299,  16'sd752,   -16'sd3646, 16'sd1061
  };

  // Trained recurrent kernel, stored row by row.
  localparam u_init_t U_INIT = '{
    -16'sd4959, 16'sd1278,  16'sd4684,  -16'sd4353,
    16'sd5651,  -16'sd1195, 16'sd990,   -16'sd5724,
    -16'sd2233, 16'sd2268,  -16'sd6519, -16'sd3806,
    -16'sd2365, -16'sd7675, -16'sd1300, -16'sd958
  };

  // Shift-subtract division, used only while the table is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-w for w in [0,1], both with 31 fraction bits, by a Taylor series.
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] w);
    logic signed [65:0] sum;
    logic [63:0] term;
    sum = '0;
    term = 64'd1 << 31;
    for (int n = 0; n < 24; n++) begin
      if (n % 2 == 1) begin
        sum = sum - $signed({2'b00, term});
      end else begin
        sum = sum + $signed({2'b00, term});
      end
      term = udiv64((term * w) >> 31, 64'(n + 1));
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed(66'd1 << 31)) begin
      sum = 66'sd1 << 31;
    end
    return sum[63:0];
  endfunction

  // tanh(8*i/TAB_N) in Q1.14 for i = 0..TAB_N.
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t tab;
    logic [63:0] w;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] t;
    for (int i = 0; i <= TAB_N; i++) begin
      w = udiv64(64'(i) << 31, 64'(TAB_N));
      e = exp_neg_q31(w);
      for (int sq = 0; sq < 4; sq++) begin
        e = (e * e) >> 31;
      end
      num = ((64'd1 << 31) - e) * 64'd32768;
      den = (64'd1 << 31) + e;
      t = udiv64(num + den, den << 1);
      if (t > 64'(H_ONE)) begin
        t = 64'(H_ONE);
      end
      tab[i] = t[14:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage
`default_nettype wire

/* hw/rtl/rtc_in_if.sv */
`default_nettype none
interface rtc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               first_of_sequence;
  logic [4:0]         weight_index;
  logic signed [15:0] weight_value;
  logic signed [15:0] x0;
  logic signed [15:0] x1;
  logic signed [15:0] x2;
  logic signed [15:0] x3;
  logic signed [15:0] x4;
  logic signed [15:0] x5;
  logic signed [15:0] x6;
  logic signed [15:0] x7;

  modport source (
    output valid, kind, first_of_sequence, weight_index, weight_value,
    output x0, x1, x2, x3, x4, x5, x6, x7,
    input  ready
  );
  modport sink (
    input  valid, kind, first_of_sequence, weight_index, weight_value,
    input  x0, x1, x2, x3, x4, x5, x6, x7,
    output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/rtc_out_if.sv */
`default_nettype none
interface rtc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] h0;
  logic signed [15:0] h1;
  logic signed [15:0] h2;
  logic signed [15:0] h3;

  modport source (output valid, h0, h1, h2, h3, input ready);
  modport sink (input valid, h0, h1, h2, h3, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rtc_ram.sv */
`default_nettype none
module rtc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

/* hw/rtl/rtc_ctrl.sv */
`default_nettype none
module rtc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  input  rtc_pkg::rtc_sts_t sts,
  output rtc_pkg::rtc_cmd_t cmd
);
  import rtc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MAC   = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_TLO   = 8'b0000_1000,
    S_THI   = 8'b0001_0000,
    S_TMUL  = 8'b0010_0000,
    S_TOUT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      term_r  <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    term_nxt  = term_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.term  = term_r;
    cmd.row   = row_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (kind_t'(in_kind))
            KIND_LOAD_W: cmd.load_w = 1'b1;
            KIND_LOAD_U: cmd.load_u = 1'b1;
            KIND_STEP: begin
              cmd.start   = 1'b1;
              cmd.acc_clr = 1'b1;
              row_nxt     = '0;
              term_nxt    = '0;
              state_nxt   = S_MAC;
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (term_r == TERM_W'(TERMS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.abs_cap = 1'b1;
          state_nxt   = S_TLO;
        end
      end
      S_TLO: begin
        cmd.tab_lo = 1'b1;
        state_nxt  = S_THI;
      end
      S_THI: begin
        cmd.tab_hi = 1'b1;
        state_nxt  = S_TMUL;
      end
      S_TMUL: begin
        cmd.tab_mul = 1'b1;
        state_nxt   = S_TOUT;
      end
      S_TOUT: begin
        cmd.h_wr = 1'b1;
        if (row_r == ROW_W'(HN - 1)) begin
          state_nxt = S_DONE;
        end else begin
          row_nxt     = row_r + 1'b1;
          term_nxt    = '0;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_MAC;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/rtc_dpath.sv */
`default_nettype none
module rtc_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  rtc_pkg::rtc_cmd_t cmd,
  output rtc_pkg::rtc_sts_t sts,
  input  logic              first_of_sequence,
  input  logic [4:0]        weight_index,
  input  rtc_pkg::word_t    weight_value,
  input  rtc_pkg::xvec_t    x_in,
  output rtc_pkg::hvec_t    h_out,
  output logic              out_valid,
  input  logic              out_ready
);
  import rtc_pkg::*;

  // Weight stores with per-entry written flags; unwritten entries read the trained value.
  logic [W_DEPTH-1:0] w_ok_r;
  logic [U_DEPTH-1:0] u_ok_r;
  logic [W_AW-1:0]    w_raddr;
  logic [U_AW-1:0]    u_raddr;
  logic [15:0]        w_q;
  logic [15:0]        u_q;
  logic               u_we;

  xvec_t x_r;
  hvec_t h_r;
  hvec_t newh_r;
  hvec_t out_r;
  logic  out_valid_r;

  logic              a_vld_r, a_rec_r, a_ok_r;
  logic [XK_W-1:0]   a_k_r;
  word_t             a_init_r;
  logic              b_vld_r, b_rec_r;
  logic signed [31:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  word_t w_sel;
  word_t opd;

  logic [ACC_W-1:0] acc_abs;
  logic             neg_r, sat_r;
  logic [29:0]      a_r;
  logic [14:0]      lo_r;
  logic [14:0]      hi;
  logic [14:0]      d_r;
  logic [36:0]      m_r;
  logic [36:0]      rnd;
  logic [15:0]      y_sum;
  logic [15:0]      y_mag;
  word_t            y_res;

  assign w_raddr = {cmd.row, cmd.term[XK_W-1:0]};
  assign u_raddr = {cmd.row, cmd.term[ROW_W-1:0]};
  assign u_we    = cmd.load_u && (weight_index < 5'(U_DEPTH));

  rtc_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wram (
    .clk   (clk),
    .we    (cmd.load_w),
    .waddr (weight_index[W_AW-1:0]),
    .wdata (weight_value),
    .raddr (w_raddr),
    .rdata (w_q)
  );

  rtc_ram #(.WIDTH(16), .DEPTH(U_DEPTH)) u_uram (
    .clk   (clk),
    .we    (u_we),
    .waddr (weight_index[U_AW-1:0]),
    .wdata (weight_value),
    .raddr (u_raddr),
    .rdata (u_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_ok_r <= '0;
      u_ok_r <= '0;
    end else begin
      if (cmd.load_w) begin
        w_ok_r[weight_index[W_AW-1:0]] <= 1'b1;
      end
      if (u_we) begin
        u_ok_r[weight_index[U_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Multiply-accumulate pipeline: weight read, product, accumulate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= cmd.issue;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_rec_r  <= cmd.term[TERM_W-1];
    a_k_r    <= cmd.term[XK_W-1:0];
    a_ok_r   <= cmd.term[TERM_W-1] ? u_ok_r[u_raddr] : w_ok_r[w_raddr];
    a_init_r <= cmd.term[TERM_W-1] ? U_INIT[u_raddr] : W_INIT[w_raddr];
    b_rec_r  <= a_rec_r;
    prod_r   <= w_sel * opd;
  end

  always_comb begin
    if (a_ok_r) begin
      w_sel = a_rec_r ? word_t'(u_q) : word_t'(w_q);
    end else begin
      w_sel = a_init_r;
    end
    opd = a_rec_r ? h_r[a_k_r[ROW_W-1:0]] : x_r[a_k_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (b_vld_r) begin
      // Input products carry 24 fraction bits and are scaled up to 27.
      acc_r <= acc_r + (b_rec_r ? ACC_W'(prod_r) : (ACC_W'(prod_r) <<< 3));
    end
  end

  // tanh by table lookup and linear interpolation.
  assign acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign hi      = TANH_TAB[TAB_AW'({1'b0, a_r[29:FRAC_W]}) + TAB_AW'(1)];
  assign rnd     = m_r + (37'd1 << (FRAC_W - 1));
  assign y_sum   = {1'b0, lo_r} + {1'b0, rnd[FRAC_W +: 15]};

  always_comb begin
    if (sat_r || (y_sum > 16'(H_ONE))) begin
      y_mag = 16'(H_ONE);
    end else begin
      y_mag = y_sum;
    end
    y_res = neg_r ? word_t'(-y_mag) : word_t'(y_mag);
  end

  always_ff @(posedge clk) begin
    if (cmd.abs_cap) begin
      neg_r <= acc_r[ACC_W-1];
      sat_r <= |acc_abs[ACC_W-1:30];
      a_r   <= acc_abs[29:0];
    end
    if (cmd.tab_lo) begin
      lo_r <= TANH_TAB[TAB_AW'({1'b0, a_r[29:FRAC_W]})];
    end
    if (cmd.tab_hi) begin
      d_r <= (hi > lo_r) ? (hi - lo_r) : '0;
    end
    if (cmd.tab_mul) begin
      m_r <= 37'(d_r) * 37'(a_r[FRAC_W-1:0]);
    end
    if (cmd.h_wr) begin
      newh_r[cmd.row] <= y_res;
    end
    if (cmd.start) begin
      x_r <= x_in;
    end
    if (cmd.commit) begin
      out_r <= newh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r         <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start && first_of_sequence) begin
        h_r <= '{default: '0};
      end else if (cmd.commit) begin
        h_r <= newh_r;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.pipe_busy = a_vld_r || b_vld_r;
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign h_out         = out_r;
  assign out_valid     = out_valid_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten while pending");
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.abs_cap |-> (!a_vld_r && !b_vld_r))
    else $error("tanh started before accumulation finished");
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result appeared without a commit");
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_clr |-> !b_vld_r)
    else $error("accumulator cleared with a product in flight");
`endif
endmodule
`default_nettype wire

/* hw/rtl/recurrent_tanh_cell.sv */
`default_nettype none
// Elman recurrent cell with tanh activation in fixed point. Each time-step transaction
// carries an 8-element input vector x (Q4.11) and produces one result transaction with
// the 4-element hidden state new_h[j] = tanh(sum W[j][k]*x[k] + sum U[j][k]*h[k]) in Q1.14,
// which the cell also keeps for the next step. A set first_of_sequence flag zeroes the
// kept state before the step. Load transactions (kind 0 for W, 1 for U) rewrite one
// weight slot and give no result; a recurrent slot past 15 is ignored, as is kind 3.
// After reset both weight stores hold the trained kernels. In a time step each of the
// four hidden rows runs 12 multiply-accumulates through the single 16x16 multiplier,
// waits for the read, product and accumulate stages to drain, and then interpolates in
// the tanh table; a start state precedes the rows, and a hand-off state after them moves
// the result to the output register once it is free or being taken. The output register
// lets the cell take the next transaction while a result still waits.
module recurrent_tanh_cell (
  input  logic       clk,
  input  logic       rst_n,
  rtc_in_if.sink     in_chan,
  rtc_out_if.source  out_chan
);
  import rtc_pkg::*;

  rtc_cmd_t cmd;
  rtc_sts_t sts;
  xvec_t    x_vec;
  hvec_t    h_vec;
  logic     in_ready;
  logic     out_valid;

  // Gather the input vector fields into one array for the datapath.
  assign x_vec[0] = in_chan.x0;
  assign x_vec[1] = in_chan.x1;
  assign x_vec[2] = in_chan.x2;
  assign x_vec[3] = in_chan.x3;
  assign x_vec[4] = in_chan.x4;
  assign x_vec[5] = in_chan.x5;
  assign x_vec[6] = in_chan.x6;
  assign x_vec[7] = in_chan.x7;

  // The controller sequences rows and tanh steps; the datapath holds the weights, vectors and arithmetic.
  rtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_kind  (in_chan.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtc_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .first_of_sequence (in_chan.first_of_sequence),
    .weight_index      (in_chan.weight_index),
    .weight_value      (in_chan.weight_value),
    .x_in              (x_vec),
    .h_out             (h_vec),
    .out_valid         (out_valid),
    .out_ready         (out_chan.ready)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.h0    = h_vec[0];
  assign out_chan.h1    = h_vec[1];
  assign out_chan.h2    = h_vec[2];
  assign out_chan.h3    = h_vec[3];
endmodule
`default_nettype wire
